[rtl/imufp_pkg.sv]
// ----------------------------------------------------------------------------
// imufp_pkg
// shared types and constants of the serial imu frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package imufp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PAY_BYTES = 8;
    localparam int unsigned PAY_W     = BYTE_W * PAY_BYTES;
    localparam int unsigned IDX_W     = 4;

    localparam logic [BYTE_W-1:0] SYNC_VALUE    = 8'h55;
    localparam logic [BYTE_W-1:0] KIND_GYRO     = 8'h52;
    localparam logic [BYTE_W-1:0] KIND_ANGLE    = 8'h53;
    localparam logic [BYTE_W-1:0] AGE_MAX       = 8'hFF;
    localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd20;

    // frame positions: sync, kind, eight payload bytes, checksum
    localparam logic [IDX_W-1:0] POS_SYNC     = 4'd0;
    localparam logic [IDX_W-1:0] POS_KIND     = 4'd1;
    localparam logic [IDX_W-1:0] POS_PAY0     = 4'd2;
    localparam logic [IDX_W-1:0] POS_CHECKSUM = 4'd10;

    // op codes of an input word
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_GOOD = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_GOOD = 2'd2,
        ACT_BAD  = 2'd3
    } t_action;

    // one classified word on its way from front to back
    typedef struct packed {
        t_action             action;
        logic [BYTE_W-1:0]   kind;
        logic [PAY_W-1:0]    payload;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/imufp_in_if.sv]
// ----------------------------------------------------------------------------
// imufp_in_if
// input word channel: received byte or timer tick
// ----------------------------------------------------------------------------
`default_nettype none

interface imufp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/imufp_out_if.sv]
// ----------------------------------------------------------------------------
// imufp_out_if
// result word channel: frame status, payload and link status
// ----------------------------------------------------------------------------
`default_nettype none

interface imufp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  frame_kind;
    logic [63:0] payload;
    logic        angle_ready;
    logic        gyro_ready;
    logic        online;
    logic [7:0]  age;

    modport source (output valid, output frame_status, output frame_kind, output payload,
                    output angle_ready, output gyro_ready, output online, output age,
                    input ready);
    modport sink   (input valid, input frame_status, input frame_kind, input payload,
                    input angle_ready, input gyro_ready, input online, input age,
                    output ready);
endinterface

`default_nettype wire

[rtl/imufp_cfg_if.sv]
// ----------------------------------------------------------------------------
// imufp_cfg_if
// configuration write channel for the timeout register
// ----------------------------------------------------------------------------
`default_nettype none

interface imufp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] timeout_ticks;

    modport source (output valid, output timeout_ticks, input ready);
    modport sink   (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

[rtl/imufp_front.sv]
// ----------------------------------------------------------------------------
// imufp_front
// framing front end: tracks frame position, checksum, kind and payload
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    imufp_in_if.sink            i_in,
    input  wire logic           i_q_ready,
    output imufp_pkg::t_cmd     o_cmd,
    output logic                o_push
);

    logic [imufp_pkg::IDX_W-1:0]  r_index, n_index;
    logic [imufp_pkg::BYTE_W-1:0] r_sum, n_sum;
    logic [imufp_pkg::BYTE_W-1:0] r_kind, n_kind;
    logic [imufp_pkg::PAY_W-1:0]  r_payload, n_payload;
    logic                         accept;
    logic [imufp_pkg::BYTE_W-1:0] b;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid & i_q_ready;
    assign o_push     = accept;
    assign b          = i_in.rx_byte;

    always_comb begin
        n_index        = r_index;
        n_sum          = r_sum;
        n_kind         = r_kind;
        n_payload      = r_payload;
        o_cmd.action   = imufp_pkg::ACT_NONE;
        o_cmd.kind     = '0;
        o_cmd.payload  = '0;
        if (i_in.op == imufp_pkg::OP_TICK) begin
            o_cmd.action = imufp_pkg::ACT_TICK;
        end else if (r_index == imufp_pkg::POS_SYNC) begin
            // anything but sync is dropped while hunting
            if (b == imufp_pkg::SYNC_VALUE) begin
                n_sum     = b;
                n_kind    = '0;
                n_payload = '0;
                n_index   = imufp_pkg::POS_KIND;
            end
        end else if (r_index == imufp_pkg::POS_KIND) begin
            n_kind  = b;
            n_sum   = r_sum + b;
            n_index = imufp_pkg::POS_PAY0;
        end else if (r_index < imufp_pkg::POS_CHECKSUM) begin
            for (int j = 0; j < int'(imufp_pkg::PAY_BYTES); j++) begin
                if (r_index == imufp_pkg::POS_PAY0 + imufp_pkg::IDX_W'(j)) begin
                    n_payload[j*imufp_pkg::BYTE_W +: imufp_pkg::BYTE_W] = b;
                end
            end
            n_sum   = r_sum + b;
            n_index = r_index + 1'b1;
        end else begin
            // checksum position
            o_cmd.kind = r_kind;
            if (r_sum == b) begin
                o_cmd.action  = imufp_pkg::ACT_GOOD;
                o_cmd.payload = r_payload;
            end else begin
                o_cmd.action  = imufp_pkg::ACT_BAD;
            end
            n_index   = imufp_pkg::POS_SYNC;
            n_sum     = '0;
            n_kind    = '0;
            n_payload = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= imufp_pkg::POS_SYNC;
            r_sum     <= '0;
            r_kind    <= '0;
            r_payload <= '0;
        end else if (accept) begin
            r_index   <= n_index;
            r_sum     <= n_sum;
            r_kind    <= n_kind;
            r_payload <= n_payload;
        end
    end

    // frame position stays within sync .. checksum
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= imufp_pkg::POS_CHECKSUM)
        else $error("frame position out of range");

    // a checksum word always takes the framer back to hunting
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.op == imufp_pkg::OP_BYTE && r_index == imufp_pkg::POS_CHECKSUM
        |=> r_index == imufp_pkg::POS_SYNC && r_sum == '0)
        else $error("framer did not restart after checksum");

    // a tick leaves the framing state alone
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.op == imufp_pkg::OP_TICK
        |=> $stable(r_index) && $stable(r_sum))
        else $error("tick disturbed framing");

endmodule

`default_nettype wire

[rtl/imufp_queue.sv]
// ----------------------------------------------------------------------------
// imufp_queue
// two-entry command queue between framer and status back end
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  imufp_pkg::t_cmd     i_cmd,
    output logic                o_ready,
    output logic                o_valid,
    input  wire logic           i_pop,
    output imufp_pkg::t_cmd     o_cmd
);

    imufp_pkg::t_cmd r_entry [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_entry[r_wr_ptr] <= i_cmd;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count overflow");

    // pointers differ exactly when one entry is held
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr != r_rd_ptr) == (r_count == 2'd1))
        else $error("queue pointers and count disagree");

endmodule

`default_nettype wire

[rtl/imufp_back.sv]
// ----------------------------------------------------------------------------
// imufp_back
// status back end: age counter, ready flags, timeout and result register
// ----------------------------------------------------------------------------
`default_nettype none

module imufp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  imufp_pkg::t_cmd     i_cmd,
    output logic                o_pop,
    imufp_cfg_if.sink           i_cfg,
    imufp_out_if.source         o_out
);

    logic [imufp_pkg::BYTE_W-1:0] r_timeout;
    logic [imufp_pkg::BYTE_W-1:0] r_age, n_age;
    logic                         r_angle, n_angle;
    logic                         r_gyro, n_gyro;
    logic                         r_valid;
    imufp_pkg::t_status           r_status, n_status;
    logic [imufp_pkg::BYTE_W-1:0] r_frame_kind;
    logic [imufp_pkg::PAY_W-1:0]  r_payload;
    logic                         r_online, n_online;

    assign i_cfg.ready = 1'b1;
    assign o_pop       = i_q_valid & (~r_valid | o_out.ready);

    always_comb begin
        n_age    = r_age;
        n_angle  = r_angle;
        n_gyro   = r_gyro;
        n_status = imufp_pkg::STATUS_NONE;
        unique case (i_cmd.action)
            imufp_pkg::ACT_TICK: begin
                if (r_age != imufp_pkg::AGE_MAX) n_age = r_age + 1'b1;
            end
            imufp_pkg::ACT_GOOD: begin
                n_status = imufp_pkg::STATUS_GOOD;
                n_age    = '0;
                if (i_cmd.kind == imufp_pkg::KIND_GYRO)  n_gyro  = 1'b1;
                if (i_cmd.kind == imufp_pkg::KIND_ANGLE) n_angle = 1'b1;
            end
            imufp_pkg::ACT_BAD: begin
                n_status = imufp_pkg::STATUS_BAD;
            end
            default: begin
                n_status = imufp_pkg::STATUS_NONE;
            end
        endcase
        n_online = n_angle & n_gyro & (n_age < r_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= imufp_pkg::TIMEOUT_RESET;
            r_age     <= '0;
            r_angle   <= 1'b0;
            r_gyro    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) r_timeout <= i_cfg.timeout_ticks;
            if (o_pop) begin
                r_age   <= n_age;
                r_angle <= n_angle;
                r_gyro  <= n_gyro;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status     <= n_status;
            r_frame_kind <= i_cmd.kind;
            r_payload    <= i_cmd.payload;
            r_online     <= n_online;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.frame_status = r_status;
    assign o_out.frame_kind   = r_frame_kind;
    assign o_out.payload      = r_payload;
    assign o_out.angle_ready  = r_angle;
    assign o_out.gyro_ready   = r_gyro;
    assign o_out.online       = r_online;
    assign o_out.age          = r_age;

    a_online_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_online |-> r_angle && r_gyro)
        else $error("online without both ready flags");

    a_good_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == imufp_pkg::STATUS_GOOD |-> r_age == '0)
        else $error("good frame left age nonzero");

    // ready flags never drop once set; checked here for the gyro flag
    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gyro |=> r_gyro)
        else $error("gyro flag cleared");

endmodule

`default_nettype wire

[rtl/imu_serial_frame_parser.sv]
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// eleven-byte sync/checksum sensor frame parser with link status
// ----------------------------------------------------------------------------
// path: a word accepted is written into the queue, then moves into the result
//   register once that register is free, behind any word still waiting in the
//   two-entry queue
// throughput: one word per cycle sustained while the result side is ready,
//   set by the framer step and the status update
// reset: synchronous active-low i_rst_n clears framing, age, flags, queue and
//   result valid, and loads the timeout register with 20
// ----------------------------------------------------------------------------
`default_nettype none

module imu_serial_frame_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    imufp_in_if.sink    i_in,
    imufp_cfg_if.sink   i_cfg,
    imufp_out_if.source o_out
);

    // command from framer into the queue
    imufp_pkg::t_cmd front_cmd;
    logic            front_push;
    logic            q_ready;

    // command from the queue into the status back end
    imufp_pkg::t_cmd back_cmd;
    logic            q_valid;
    logic            back_pop;

    // front end: hunts for sync, tracks position and running checksum,
    // classifies each word as tick, nothing, good frame or bad frame
    imufp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_cmd     (front_cmd),
        .o_push    (front_push)
    );

    // short queue lets the framer keep taking words while results stall
    imufp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (back_pop),
        .o_cmd   (back_cmd)
    );

    // back end: age counter, sticky ready flags, online compare against
    // the timeout register, and the result register
    imufp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (back_cmd),
        .o_pop     (back_pop),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

[tb/sv/imu_serial_frame_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_tb
// self-checking bench for the serial imu frame parser: byte and tick words
// go in through the input channel, every result word is compared field by
// field against a cycle-free model of framing, checksum, age and link status
// ----------------------------------------------------------------------------

import imufp_pkg::*;

// one result word as the block presents it
typedef struct packed {
    t_status             status;
    logic [BYTE_W-1:0]   kind;
    logic [PAY_W-1:0]    payload;
    logic                angle;
    logic                gyro;
    logic                online;
    logic [BYTE_W-1:0]   age;
} t_frame_result;

// framing and link status model plus the queue of result words still due
class imu_link_scoreboard;
    logic [BYTE_W-1:0]  timeout_val;
    logic [IDX_W-1:0]   frame_pos;
    logic [BYTE_W-1:0]  frame_sum;
    logic [BYTE_W-1:0]  frame_kind;
    logic [PAY_W-1:0]   frame_payload;
    logic [BYTE_W-1:0]  age_cnt;
    logic               angle_flag;
    logic               gyro_flag;
    t_frame_result      due_status[$];
    int                 n_errors;
    int                 n_checked;
    int                 n_good;
    int                 n_bad;
    int                 n_ticks;
    int                 n_online;
    int                 n_saturated;

    function new();
        timeout_val   = TIMEOUT_RESET;
        frame_pos     = POS_SYNC;
        frame_sum     = '0;
        frame_kind    = '0;
        frame_payload = '0;
        age_cnt       = '0;
        angle_flag    = 1'b0;
        gyro_flag     = 1'b0;
        n_errors      = 0;
        n_checked     = 0;
        n_good        = 0;
        n_bad         = 0;
        n_ticks       = 0;
        n_online      = 0;
        n_saturated   = 0;
    endfunction

    function void set_timeout(logic [BYTE_W-1:0] value);
        timeout_val = value;
    endfunction

    function int pending();
        return due_status.size();
    endfunction

    // advance the framer by one accepted word and queue the result it causes
    function void take_word(logic op, logic [BYTE_W-1:0] rx);
        t_frame_result r;
        r.status  = STATUS_NONE;
        r.kind    = '0;
        r.payload = '0;
        if (op == OP_TICK) begin
            n_ticks++;
            if (age_cnt != AGE_MAX) age_cnt++;
        end else if (frame_pos == POS_SYNC) begin
            if (rx == SYNC_VALUE) begin
                frame_sum     = rx;
                frame_kind    = '0;
                frame_payload = '0;
                frame_pos     = POS_KIND;
            end
        end else if (frame_pos == POS_KIND) begin
            frame_kind = rx;
            frame_sum  = frame_sum + rx;
            frame_pos  = POS_PAY0;
        end else if (frame_pos < POS_CHECKSUM) begin
            frame_payload[BYTE_W*(frame_pos-POS_PAY0) +: BYTE_W] = rx;
            frame_sum = frame_sum + rx;
            frame_pos = frame_pos + 1'b1;
        end else begin
            r.kind = frame_kind;
            if (frame_sum == rx) begin
                r.status  = STATUS_GOOD;
                r.payload = frame_payload;
                age_cnt   = '0;
                if (frame_kind == KIND_GYRO) gyro_flag = 1'b1;
                else if (frame_kind == KIND_ANGLE) angle_flag = 1'b1;
            end else begin
                r.status = STATUS_BAD;
            end
            frame_pos     = POS_SYNC;
            frame_sum     = '0;
            frame_kind    = '0;
            frame_payload = '0;
        end
        r.angle  = angle_flag;
        r.gyro   = gyro_flag;
        r.online = angle_flag && gyro_flag && (age_cnt < timeout_val);
        r.age    = age_cnt;
        due_status.push_back(r);
    endfunction

    task report(string msg);
        n_errors++;
        if (n_errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_status_word(t_frame_result got);
        t_frame_result want;
        n_checked++;
        if (due_status.size() == 0) begin
            report($sformatf("result word %0d arrived with nothing due", n_checked));
            return;
        end
        want = due_status.pop_front();
        if (got.status !== want.status)
            report($sformatf("word %0d frame_status %h, want %h", n_checked, got.status,
                             want.status));
        if (got.kind !== want.kind)
            report($sformatf("word %0d frame_kind %h, want %h", n_checked, got.kind, want.kind));
        if (got.payload !== want.payload)
            report($sformatf("word %0d payload %h, want %h", n_checked, got.payload,
                             want.payload));
        if (got.angle !== want.angle)
            report($sformatf("word %0d angle_ready %b, want %b", n_checked, got.angle,
                             want.angle));
        if (got.gyro !== want.gyro)
            report($sformatf("word %0d gyro_ready %b, want %b", n_checked, got.gyro, want.gyro));
        if (got.online !== want.online)
            report($sformatf("word %0d online %b, want %b", n_checked, got.online, want.online));
        if (got.age !== want.age)
            report($sformatf("word %0d age %0d, want %0d", n_checked, got.age, want.age));
        if (want.status == STATUS_GOOD) n_good++;
        if (want.status == STATUS_BAD) n_bad++;
        if (want.online) n_online++;
        if (want.age == AGE_MAX) n_saturated++;
    endtask
endclass

module imu_serial_frame_parser_tb;

    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    imufp_in_if  in_ch ();
    imufp_cfg_if cfg_ch ();
    imufp_out_if out_ch ();

    imu_serial_frame_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    imu_link_scoreboard sb;

    // pacing knobs, percent chance of starting an idle burst per word or cycle
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit quiet_tail    = 1'b0;
    int words_sent    = 0;
    logic [BYTE_W-1:0] mid_timeout;
    logic [BYTE_W-1:0] tail_timeout;

    always #10 i_clk = ~i_clk;

    // every input driven to a known value before the first edge
    initial begin
        in_ch.valid          = 1'b0;
        in_ch.op             = OP_BYTE;
        in_ch.rx_byte        = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.timeout_ticks = '0;
    end

    // ------------------------------------------------------------------------
    // result side back-pressure: ready drops at random for bursts of idle cycles
    // ------------------------------------------------------------------------
    initial begin : sink_pacing
        int hold;
        out_ch.ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0 && !quiet_tail) begin
                hold--;
            end else if (!quiet_tail && sink_idle_pct != 0 &&
                         $urandom_range(1, 100) <= sink_idle_pct) begin
                out_ch.ready = 1'b0;
                hold = $urandom_range(0, 16);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: everything sampled at the rising edge, results checked before
    // the word accepted on the same edge is fed to the model
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : bus_monitor
        t_frame_result got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.status  = t_status'(out_ch.frame_status);
                got.kind    = out_ch.frame_kind;
                got.payload = out_ch.payload;
                got.angle   = out_ch.angle_ready;
                got.gyro    = out_ch.gyro_ready;
                got.online  = out_ch.online;
                got.age     = out_ch.age;
                sb.check_status_word(got);
            end
            if (in_ch.valid && in_ch.ready) sb.take_word(in_ch.op, in_ch.rx_byte);
            if (cfg_ch.valid && cfg_ch.ready) sb.set_timeout(cfg_ch.timeout_ticks);
        end
    end

    // watchdog on the whole run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d result words still due", cycles,
                 sb.pending());
        $display("Verification failed");
        $finish;
    end

    // one word on the input channel; entered and left at a falling edge,
    // valid stays high between back-to-back words
    task automatic send_word(input logic op, input logic [BYTE_W-1:0] rx);
        if (!quiet_tail && src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.op      = op;
        in_ch.rx_byte = rx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // full frame: sync, kind, payload low byte first, checksum; tick_at puts one
    // tick in front of that frame position, tick_pct sprinkles more
    task automatic send_frame(input logic [BYTE_W-1:0] kind, input logic [PAY_W-1:0] pay,
                              input bit corrupt, input int tick_at, input int tick_pct);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] byte_val;
        int                pos;
        sum = SYNC_VALUE;
        send_word(OP_BYTE, SYNC_VALUE);
        for (pos = 1; pos <= 10; pos++) begin
            if (pos == tick_at || (tick_pct != 0 && $urandom_range(1, 100) <= tick_pct))
                send_word(OP_TICK, 8'($urandom_range(0, 255)));
            if (pos == 1) byte_val = kind;
            else if (pos < 10) byte_val = pay[BYTE_W*(pos-2) +: BYTE_W];
            else if (corrupt) byte_val = sum ^ 8'($urandom_range(1, 255));
            else byte_val = sum;
            if (pos < 10) sum = sum + byte_val;
            send_word(OP_BYTE, byte_val);
        end
    endtask

    // mostly well-formed frames with random content, plus line noise, ticks
    // and frames cut short
    task automatic run_random(input int n_words);
        int                stop_at;
        int                pick;
        int                slot;
        logic [BYTE_W-1:0] kind;
        logic [PAY_W-1:0]  pay;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 4))
                    0, 1:    kind = KIND_GYRO;
                    2, 3:    kind = KIND_ANGLE;
                    default: kind = 8'($urandom_range(0, 255));
                endcase
                pay = {$urandom, $urandom};
                if ($urandom_range(0, 9) == 0) begin
                    slot = $urandom_range(0, PAY_BYTES - 1);
                    pay[BYTE_W*slot +: BYTE_W] = SYNC_VALUE;
                end
                send_frame(kind, pay, $urandom_range(0, 6) == 0, 0, 8);
            end else if (pick < 82) begin
                send_word(OP_BYTE, 8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                send_word(OP_TICK, 8'($urandom_range(0, 255)));
            end else begin
                // broken frame, the next frame then lands out of step
                send_word(OP_BYTE, SYNC_VALUE);
                repeat ($urandom_range(0, 8)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // stop sending and let every due result word come out
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [BYTE_W-1:0] value);
        cfg_ch.valid         = 1'b1;
        cfg_ch.timeout_ticks = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_pacing(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb = new();
        mid_timeout  = 8'($urandom_range(2, 254));
        tail_timeout = 8'($urandom_range(3, 30));

        // reset held low from the start, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part, timeout still at its reset value
        set_pacing(10, 10);
        // bytes outside a frame are dropped
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_TICK, 8'hFF);
        // good gyro frame, sync value twice inside the payload, tick mid frame
        send_frame(KIND_GYRO, 64'h55AA_7F80_0155_FF00, 1'b0, 5, 0);
        // angle frame with a wrong checksum: kind reported, no flag, no age clear
        send_frame(KIND_ANGLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, 0);

        // random at reset timeout, both sides idling
        set_pacing(12, 12);
        run_random(60);

        // zero timeout, link can never come up
        wait_drained();
        write_timeout(8'd0);
        set_pacing(0, 20);
        run_random(40);

        // widest timeout, then enough ticks to pin the age at its ceiling
        wait_drained();
        write_timeout(8'd255);
        set_pacing(0, 0);
        send_frame(KIND_GYRO, {$urandom, $urandom}, 1'b0, 0, 0);
        send_frame(KIND_ANGLE, {$urandom, $urandom}, 1'b0, 0, 0);
        repeat (258) send_word(OP_TICK, 8'($urandom_range(0, 255)));
        set_pacing(15, 5);
        run_random(20);

        // timeout of one, online only right after a good frame
        wait_drained();
        write_timeout(8'd1);
        set_pacing(20, 0);
        run_random(30);

        // some middle value
        wait_drained();
        write_timeout(mid_timeout);
        set_pacing(8, 8);
        run_random(30);

        // closing stretch with no idling on either side
        wait_drained();
        write_timeout(tail_timeout);
        quiet_tail = 1'b1;
        set_pacing(0, 0);
        run_random(30);

        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("checked %0d result words: %0d good frames, %0d bad checksums, %0d ticks",
                 sb.n_checked, sb.n_good, sb.n_bad, sb.n_ticks);
        $display("timeouts 20, 0, 255, 1, %0d, %0d; %0d words online, %0d at age ceiling",
                 mid_timeout, tail_timeout, sb.n_online, sb.n_saturated);
        if (sb.n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/imufp_pkg.sv
rtl/imufp_in_if.sv
rtl/imufp_out_if.sv
rtl/imufp_cfg_if.sv
rtl/imufp_front.sv
rtl/imufp_queue.sv
rtl/imufp_back.sv
rtl/imu_serial_frame_parser.sv
tb/sv/imu_serial_frame_parser_tb.sv
